// File: sv/transformed_aabb_merge_macros.svh
// Assertion macros for the transformed bounding-box merge checker.
// Used by the checker file only; expects clk_i and rst_ni in scope.
`ifndef TRANSFORMED_AABB_MERGE_MACROS_SVH
`define TRANSFORMED_AABB_MERGE_MACROS_SVH

// Checked at every clock edge outside reset.
`define TAAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define TAAB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/taabb_pkg.sv
// Package for the transformed bounding-box merge: widths, defaults and
// configuration register indexes. No dependencies.
`default_nettype none

package taabb_pkg;

  localparam int FIELD_W         = 32;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int NUM_AXES        = 3;
  localparam int NUM_CORNERS     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: sv/taabb_if.sv
// Valid/ready channel interfaces for box words in and merged box words out.
// Depends on taabb_pkg for the field width.
`default_nettype none

interface taabb_in_if
  import taabb_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] local_min_x;
  logic signed [FIELD_W-1:0] local_min_y;
  logic signed [FIELD_W-1:0] local_min_z;
  logic signed [FIELD_W-1:0] local_max_x;
  logic signed [FIELD_W-1:0] local_max_y;
  logic signed [FIELD_W-1:0] local_max_z;
  logic                      last_box;

  modport source (
    output valid, local_min_x, local_min_y, local_min_z,
           local_max_x, local_max_y, local_max_z, last_box,
    input  ready
  );
  modport sink (
    input  valid, local_min_x, local_min_y, local_min_z,
           local_max_x, local_max_y, local_max_z, last_box,
    output ready
  );
endinterface

interface taabb_out_if
  import taabb_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] world_min_x;
  logic signed [FIELD_W-1:0] world_min_y;
  logic signed [FIELD_W-1:0] world_min_z;
  logic signed [FIELD_W-1:0] world_max_x;
  logic signed [FIELD_W-1:0] world_max_y;
  logic signed [FIELD_W-1:0] world_max_z;
  logic                      overflow;

  modport source (
    output valid, world_min_x, world_min_y, world_min_z,
           world_max_x, world_max_y, world_max_z, overflow,
    input  ready
  );
  modport sink (
    input  valid, world_min_x, world_min_y, world_min_z,
           world_max_x, world_max_y, world_max_z, overflow,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/transformed_aabb_merge.sv
// Transformed bounding-box merge: affine transform of box corners and merge.
// Depends on taabb_pkg and the channel interfaces in taabb_if.sv.
//
// Usage: box_i carries one local box word per transfer (min and max corner,
// signed fixed point, plus last_box). Each box's eight corners go through
// the 3x4 affine matrix held in six 64-bit registers, which the user must
// write over the cfg_we_i / cfg_idx_i / cfg_wdata_i port only while the
// block is idle; the block does not enforce this. The per-axis extremes
// of all corners are merged until a word with last_box set, which produces
// one merged box word on box_o and restarts the merge. A last word passes
// the input register, products, sums, rounded corners, corner extremes and
// the output register. Throughput: one box word per cycle unless stalled,
// set by the five-stage pipeline with one multiplier per linear term and
// polarity. Reset clears the pipeline, the output valid flag and the merge
// state and loads the identity matrix. When box_o stalls, a waiting result
// holds its register; words without last_box keep flowing into the merge,
// and the pipeline backs up only behind a second last word.
`default_nettype none

module transformed_aabb_merge
  import taabb_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  taabb_in_if.sink                  box_i,
  taabb_out_if.source               box_o
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * CW;
  localparam int SW = 2 * CW + 3;
  localparam int NS = 5;
  localparam int HALF_W = CFG_W / 2;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = ~C_MAX;
  localparam logic signed [CW-1:0] C_ONE = CW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] SAT_HI = SW'(C_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(C_MIN);
  localparam logic signed [SW-1:0] RND_HALF = SW'(64'd1 << (FRAC_BITS - 1));

  // Matrix registers and configuration decode.
  logic signed [CW-1:0] m_q [NUM_AXES][4];
  logic                 cfg_hit;
  logic [1:0]           cfg_row;
  logic                 cfg_odd;

  always_comb begin
    cfg_hit = 1'b1;
    cfg_row = 2'd0;
    cfg_odd = 1'b0;
    unique case (cfg_idx_e'(cfg_idx_i))
      REG_ROW0_COLS01: begin cfg_row = 2'd0; cfg_odd = 1'b0; end
      REG_ROW0_COLS23: begin cfg_row = 2'd0; cfg_odd = 1'b1; end
      REG_ROW1_COLS01: begin cfg_row = 2'd1; cfg_odd = 1'b0; end
      REG_ROW1_COLS23: begin cfg_row = 2'd1; cfg_odd = 1'b1; end
      REG_ROW2_COLS01: begin cfg_row = 2'd2; cfg_odd = 1'b0; end
      REG_ROW2_COLS23: begin cfg_row = 2'd2; cfg_odd = 1'b1; end
      default:         cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < 4; c++) begin
          m_q[r][c] <= (r == c) ? C_ONE : '0;
        end
      end
    end else if (cfg_we_i && cfg_hit) begin
      m_q[cfg_row][{cfg_odd, 1'b0}] <= cfg_wdata_i[CW-1:0];
      m_q[cfg_row][{cfg_odd, 1'b1}] <= cfg_wdata_i[HALF_W+CW-1:HALF_W];
    end
  end

  // Pipeline flow control.
  logic [NS-1:0] v_q, v_d, rdy, ld;
  logic [NS-1:0] last_q;
  logic          out_valid_q, out_valid_d;
  logic          fire;

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || !last_q[NS-1] || !out_valid_q || box_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? box_i.valid : v_q[0];
    ld[0]  = rdy[0] && box_i.valid;
    for (int k = 1; k < NS; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
      ld[k]  = rdy[k] && v_q[k-1];
    end
    fire = v_q[NS-1] && rdy[NS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign box_i.ready = rdy[0];

  // Stage 0: input register.
  logic signed [CW-1:0] lo_q [NUM_AXES];
  logic signed [CW-1:0] hi_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      lo_q[0]   <= box_i.local_min_x[CW-1:0];
      lo_q[1]   <= box_i.local_min_y[CW-1:0];
      lo_q[2]   <= box_i.local_min_z[CW-1:0];
      hi_q[0]   <= box_i.local_max_x[CW-1:0];
      hi_q[1]   <= box_i.local_max_y[CW-1:0];
      hi_q[2]   <= box_i.local_max_z[CW-1:0];
      last_q[0] <= box_i.last_box;
    end
  end

  // Stage 1: each linear matrix term times the min and the max coordinate.
  logic signed [PW-1:0] prod_q [NUM_AXES][NUM_AXES][2];

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          prod_q[r][c][0] <= PW'(m_q[r][c]) * PW'(lo_q[c]);
          prod_q[r][c][1] <= PW'(m_q[r][c]) * PW'(hi_q[c]);
        end
      end
      last_q[1] <= last_q[0];
    end
  end

  // Stage 2: per corner and axis, the exact dot product plus one half.
  logic signed [SW-1:0] sum_q [NUM_CORNERS][NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          sum_q[k][a] <= SW'(prod_q[a][0][k[0]]) + SW'(prod_q[a][1][k[1]])
                       + SW'(prod_q[a][2][k[2]]) + RND_HALF;
        end
      end
      last_q[2] <= last_q[1];
    end
  end

  // Stage 3: drop the fraction, add the translation, saturate.
  logic signed [CW-1:0]    crd_q [NUM_CORNERS][NUM_AXES];
  logic [NUM_CORNERS-1:0]  csat_q;
  logic signed [CW-1:0]    crd_d [NUM_CORNERS][NUM_AXES];
  logic [NUM_CORNERS-1:0]  csat_d;

  always_comb begin
    logic signed [SW-1:0] s;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      csat_d[k] = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        s = (sum_q[k][a] >>> FRAC_BITS) + SW'(m_q[a][3]);
        if (s > SAT_HI) begin
          crd_d[k][a] = C_MAX;
          csat_d[k]   = 1'b1;
        end else if (s < SAT_LO) begin
          crd_d[k][a] = C_MIN;
          csat_d[k]   = 1'b1;
        end else begin
          crd_d[k][a] = s[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      crd_q     <= crd_d;
      csat_q    <= csat_d;
      last_q[3] <= last_q[2];
    end
  end

  // Stage 4: extremes over the eight corners.
  logic signed [CW-1:0] bmin_q [NUM_AXES];
  logic signed [CW-1:0] bmax_q [NUM_AXES];
  logic                 bsat_q;
  logic signed [CW-1:0] bmin_d [NUM_AXES];
  logic signed [CW-1:0] bmax_d [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      bmin_d[a] = crd_q[0][a];
      bmax_d[a] = crd_q[0][a];
      for (int k = 1; k < NUM_CORNERS; k++) begin
        if (crd_q[k][a] < bmin_d[a]) bmin_d[a] = crd_q[k][a];
        if (crd_q[k][a] > bmax_d[a]) bmax_d[a] = crd_q[k][a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      bmin_q    <= bmin_d;
      bmax_q    <= bmax_d;
      bsat_q    <= |csat_q;
      last_q[4] <= last_q[3];
    end
  end

  // Merge state and result register.
  logic signed [CW-1:0] acc_min_q [NUM_AXES];
  logic signed [CW-1:0] acc_max_q [NUM_AXES];
  logic                 sat_seen_q;
  logic signed [CW-1:0] mrg_min [NUM_AXES];
  logic signed [CW-1:0] mrg_max [NUM_AXES];
  logic                 mrg_sat;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mrg_min[a] = (bmin_q[a] < acc_min_q[a]) ? bmin_q[a] : acc_min_q[a];
      mrg_max[a] = (bmax_q[a] > acc_max_q[a]) ? bmax_q[a] : acc_max_q[a];
    end
    mrg_sat = sat_seen_q || bsat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        acc_min_q[a] <= C_MAX;
        acc_max_q[a] <= C_MIN;
      end
      sat_seen_q <= 1'b0;
    end else if (fire) begin
      if (last_q[NS-1]) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          acc_min_q[a] <= C_MAX;
          acc_max_q[a] <= C_MIN;
        end
        sat_seen_q <= 1'b0;
      end else begin
        acc_min_q  <= mrg_min;
        acc_max_q  <= mrg_max;
        sat_seen_q <= mrg_sat;
      end
    end
  end

  always_comb begin
    if (fire && last_q[NS-1]) begin
      out_valid_d = 1'b1;
    end else if (box_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  logic signed [FIELD_W-1:0] wmin_q [NUM_AXES];
  logic signed [FIELD_W-1:0] wmax_q [NUM_AXES];
  logic                      ovf_q;

  always_ff @(posedge clk_i) begin
    if (fire && last_q[NS-1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        wmin_q[a] <= FIELD_W'(mrg_min[a]);
        wmax_q[a] <= FIELD_W'(mrg_max[a]);
      end
      ovf_q <= mrg_sat;
    end
  end

  assign box_o.valid       = out_valid_q;
  assign box_o.world_min_x = wmin_q[0];
  assign box_o.world_min_y = wmin_q[1];
  assign box_o.world_min_z = wmin_q[2];
  assign box_o.world_max_x = wmax_q[0];
  assign box_o.world_max_y = wmax_q[1];
  assign box_o.world_max_z = wmax_q[2];
  assign box_o.overflow    = ovf_q;

endmodule

`default_nettype wire

// File: sv/taabb_checker.sv
// Port-level checks for the transformed bounding-box merge, bound to the top.
// Depends on taabb_pkg and transformed_aabb_merge_macros.svh.
`default_nettype none

`include "transformed_aabb_merge_macros.svh"

module taabb_checker
  import taabb_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      in_last,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [FIELD_W-1:0] min_x,
  input wire logic signed [FIELD_W-1:0] min_y,
  input wire logic signed [FIELD_W-1:0] min_z,
  input wire logic signed [FIELD_W-1:0] max_x,
  input wire logic signed [FIELD_W-1:0] max_y,
  input wire logic signed [FIELD_W-1:0] max_z,
  input wire logic                      overflow
);

  // Count of closing words taken in whose merged box is not yet delivered.
  logic [2:0] pend_q;
  logic       take_last;
  logic       give;

  assign take_last = in_valid && in_ready && in_last;
  assign give      = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (take_last && !give) begin
      pend_q <= pend_q + 3'd1;
    end else if (give && !take_last) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  `TAAB_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_valid, "result valid in reset")
  `TAAB_ASSERT(a_result_owed, out_valid |-> pend_q != 3'd0, "result without last word")
  `TAAB_ASSERT(a_box_order, out_valid |-> (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z), "merged box inverted")
  `TAAB_ASSERT(a_ready_free, !out_valid |-> in_ready, "input stalled with empty output")
  `TAAB_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(min_x) && $stable(max_x) && $stable(min_y) && $stable(max_y) && $stable(min_z) && $stable(max_z) && $stable(overflow), "stalled result changed")

endmodule

bind transformed_aabb_merge taabb_checker u_taabb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (box_i.valid),
  .in_ready  (box_i.ready),
  .in_last   (box_i.last_box),
  .out_valid (box_o.valid),
  .out_ready (box_o.ready),
  .min_x     (box_o.world_min_x),
  .min_y     (box_o.world_min_y),
  .min_z     (box_o.world_min_z),
  .max_x     (box_o.world_max_x),
  .max_y     (box_o.world_max_y),
  .max_z     (box_o.world_max_z),
  .overflow  (box_o.overflow)
);

`default_nettype wire
